FILE: sv/cfe_pkg.sv
`timescale 1ns / 1ps
package cfe_pkg;

    // Token kinds
    localparam logic [3:0] KIND_INT   = 4'd0;
    localparam logic [3:0] KIND_BOOL  = 4'd1;
    localparam logic [3:0] KIND_BYTE  = 4'd2;
    localparam logic [3:0] KIND_LIST  = 4'd3;
    localparam logic [3:0] KIND_BIN   = 4'd4;
    localparam logic [3:0] KIND_SELEM = 4'd5;
    localparam logic [3:0] KIND_UVAR  = 4'd6;
    localparam logic [3:0] KIND_RAW   = 4'd7;
    localparam logic [3:0] KIND_START = 4'd8;
    localparam logic [3:0] KIND_STOP  = 4'd9;

    // Compact protocol type codes
    localparam logic [3:0] TYPE_TRUE   = 4'd1;
    localparam logic [3:0] TYPE_FALSE  = 4'd2;
    localparam logic [3:0] TYPE_I8     = 4'd3;
    localparam logic [3:0] TYPE_I16    = 4'd4;
    localparam logic [3:0] TYPE_I32    = 4'd5;
    localparam logic [3:0] TYPE_I64    = 4'd6;
    localparam logic [3:0] TYPE_BINARY = 4'd8;
    localparam logic [3:0] TYPE_LIST   = 4'd9;
    localparam logic [3:0] TYPE_STRUCT = 4'd12;

    // Integer size codes
    localparam logic [1:0] ISZ_I16 = 2'd0;
    localparam logic [1:0] ISZ_I32 = 2'd1;
    localparam logic [1:0] ISZ_I64 = 2'd2;

    localparam logic [7:0] STOP_BYTE = 8'h00;

    // Source of an emitted byte
    typedef enum logic [1:0] {
        SRC_HDR,
        SRC_VARINT,
        SRC_MID
    } cfe_src_t;

    // Which byte groups a token produces
    typedef struct packed {
        logic any;
        logic hdr;
        logic fidv;
        logic mid;
        logic tail;
    } cfe_plan_t;

    typedef struct packed {
        logic     load;
        logic     emit;
        cfe_src_t src;
        logic     last;
        logic     sr_step;
        logic     sr_tail;
    } cfe_cmd_t;

    typedef struct packed {
        cfe_plan_t plan_in;
        cfe_plan_t plan;
        logic      sr_more;
        logic      out_free;
    } cfe_stat_t;

endpackage

FILE: sv/cfe_in_if.sv
`timescale 1ns / 1ps
interface cfe_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         kind;
    logic signed [15:0] fld_id;
    logic [1:0]         int_size;
    logic signed [63:0] value;
    logic [31:0]        count;
    logic [3:0]         element_type;

    modport source (
        output valid, kind, fld_id, int_size, value, count, element_type,
        input  ready
    );
    modport sink (
        input  valid, kind, fld_id, int_size, value, count, element_type,
        output ready
    );
endinterface

FILE: sv/cfe_out_if.sv
`timescale 1ns / 1ps
interface cfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    logic       error;

    modport source (
        output valid, out_byte, last, error,
        input  ready
    );
    modport sink (
        input  valid, out_byte, last, error,
        output ready
    );
endinterface

FILE: sv/cfe_datapath.sv
`timescale 1ns / 1ps
module cfe_datapath #(
    parameter int NEST_DEPTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [3:0]         kind,
    input  logic signed [15:0] fld_id,
    input  logic [1:0]         int_size,
    input  logic signed [63:0] value,
    input  logic [31:0]        count,
    input  logic [3:0]         element_type,
    input  cfe_pkg::cfe_cmd_t  cmd,
    output cfe_pkg::cfe_stat_t stat,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [7:0]         out_byte,
    output logic               out_last,
    output logic               out_error
);

    localparam int LVL_W = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(NEST_DEPTH - 1);

    // Saved last field ids of the enclosing levels; the current level's id
    // lives in cur_id_reg.
    logic [15:0] stack_mem [NEST_DEPTH];

    logic [LVL_W-1:0] level_reg, level_next;
    logic [15:0]      cur_id_reg, cur_id_next;
    logic             restore_reg, restore_next;
    logic             out_valid_reg, out_valid_next;
    logic [15:0]      rd_data_reg;

    cfe_pkg::cfe_plan_t plan_reg;
    logic [7:0]         hdr_byte_reg;
    logic [7:0]         mid_byte_reg;
    logic [63:0]        tail_reg;
    logic [63:0]        sr_reg;
    logic               err_reg;
    logic [7:0]         out_byte_reg;
    logic               out_last_reg;
    logic               out_err_reg;

    logic [16:0]        diff;
    logic               packed_hdr;
    logic [3:0]         type_code;
    logic [7:0]         hdr_byte;
    logic [16:0]        zz_fid;
    logic [63:0]        zz_value;
    logic [63:0]        tail_val;
    logic               count_big;
    logic [7:0]         mid_byte;
    logic               hdr_kind;
    logic               overflow;
    logic               mem_we;
    logic               mem_re;
    logic [LVL_W-1:0]   pop_addr;
    logic               sr_more;
    cfe_pkg::cfe_plan_t plan_in;

    // Decode of the item at the input.
    always_comb
    begin
        diff       = {fld_id[15], fld_id} - {cur_id_reg[15], cur_id_reg};
        packed_hdr = (diff[16:4] == 13'd0) && (diff[3:0] != 4'd0);
        hdr_kind   = (kind <= cfe_pkg::KIND_BIN) || (kind == cfe_pkg::KIND_START);
        count_big  = (count[31:4] != 28'd0) || (count[3:0] == 4'hf);
        zz_fid     = {fld_id, 1'b0} ^ {17{fld_id[15]}};
        zz_value   = {value[62:0], 1'b0} ^ {64{value[63]}};
        overflow   = (kind == cfe_pkg::KIND_START) && (level_reg == LVL_TOP);

        case (kind)
            cfe_pkg::KIND_INT:
            begin
                if (int_size == cfe_pkg::ISZ_I16)
                    type_code = cfe_pkg::TYPE_I16;
                else if (int_size == cfe_pkg::ISZ_I32)
                    type_code = cfe_pkg::TYPE_I32;
                else
                    type_code = cfe_pkg::TYPE_I64;
            end
            cfe_pkg::KIND_BOOL:  type_code = value[0] ? cfe_pkg::TYPE_TRUE
                                                      : cfe_pkg::TYPE_FALSE;
            cfe_pkg::KIND_BYTE:  type_code = cfe_pkg::TYPE_I8;
            cfe_pkg::KIND_LIST:  type_code = cfe_pkg::TYPE_LIST;
            cfe_pkg::KIND_BIN:   type_code = cfe_pkg::TYPE_BINARY;
            default:             type_code = cfe_pkg::TYPE_STRUCT;
        endcase
        hdr_byte = packed_hdr ? {diff[3:0], type_code} : {4'h0, type_code};

        case (kind)
            cfe_pkg::KIND_LIST: mid_byte = {(count_big ? 4'hf : count[3:0]), element_type};
            cfe_pkg::KIND_STOP: mid_byte = cfe_pkg::STOP_BYTE;
            default:            mid_byte = value[7:0];
        endcase

        if ((kind == cfe_pkg::KIND_INT) || (kind == cfe_pkg::KIND_SELEM))
            tail_val = zz_value;
        else
            tail_val = {32'd0, count};

        plan_in.any  = (kind <= cfe_pkg::KIND_STOP);
        plan_in.hdr  = hdr_kind;
        plan_in.fidv = hdr_kind && !packed_hdr;
        plan_in.mid  = (kind == cfe_pkg::KIND_BYTE) || (kind == cfe_pkg::KIND_LIST)
                    || (kind == cfe_pkg::KIND_RAW) || (kind == cfe_pkg::KIND_STOP);
        plan_in.tail = (kind == cfe_pkg::KIND_INT) || (kind == cfe_pkg::KIND_BIN)
                    || (kind == cfe_pkg::KIND_SELEM) || (kind == cfe_pkg::KIND_UVAR)
                    || ((kind == cfe_pkg::KIND_LIST) && count_big);
    end

    // Nesting state: updated when a transaction is accepted. A pop reads the
    // saved id from memory into rd_data_reg, and restore_reg then has it copied into cur_id_reg.
    always_comb
    begin
        level_next     = level_reg;
        cur_id_next    = cur_id_reg;
        restore_next   = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        pop_addr       = level_reg - LVL_W'(1);
        out_valid_next = out_valid_reg;

        if (restore_reg)
            cur_id_next = rd_data_reg;

        if (cmd.load)
        begin
            case (kind)
                cfe_pkg::KIND_INT, cfe_pkg::KIND_BOOL, cfe_pkg::KIND_BYTE,
                cfe_pkg::KIND_LIST, cfe_pkg::KIND_BIN:
                    cur_id_next = fld_id;
                cfe_pkg::KIND_START:
                begin
                    if (overflow)
                        cur_id_next = fld_id;
                    else
                    begin
                        mem_we      = 1'b1;
                        cur_id_next = 16'd0;
                        level_next  = level_reg + LVL_W'(1);
                    end
                end
                cfe_pkg::KIND_STOP:
                begin
                    if (level_reg != '0)
                    begin
                        mem_re       = 1'b1;
                        restore_next = 1'b1;
                        level_next   = pop_addr;
                    end
                    else
                        cur_id_next = 16'd0;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            cur_id_reg    <= 16'd0;
            restore_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            level_reg     <= level_next;
            cur_id_reg    <= cur_id_next;
            restore_reg   <= restore_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            stack_mem[level_reg] <= fld_id;
        if (mem_re)
            rd_data_reg <= stack_mem[pop_addr];
    end

    assign sr_more = (sr_reg[63:7] != 57'd0);

    // Item registers and the varint shifter.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            plan_reg     <= plan_in;
            hdr_byte_reg <= hdr_byte;
            mid_byte_reg <= mid_byte;
            tail_reg     <= tail_val;
            err_reg      <= overflow;
            sr_reg       <= plan_in.fidv ? {47'd0, zz_fid} : tail_val;
        end
        else if (cmd.sr_tail)
            sr_reg <= tail_reg;
        else if (cmd.sr_step)
            sr_reg <= {7'd0, sr_reg[63:7]};

        if (cmd.emit)
        begin
            case (cmd.src)
                cfe_pkg::SRC_HDR:    out_byte_reg <= hdr_byte_reg;
                cfe_pkg::SRC_VARINT: out_byte_reg <= {sr_more, sr_reg[6:0]};
                default:             out_byte_reg <= mid_byte_reg;
            endcase
            out_last_reg <= cmd.last;
            out_err_reg  <= err_reg;
        end
    end

    assign stat.plan_in  = plan_in;
    assign stat.plan     = plan_reg;
    assign stat.sr_more  = sr_more;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_error = out_err_reg;

endmodule

FILE: sv/cfe_ctrl.sv
`timescale 1ns / 1ps
module cfe_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cfe_pkg::cfe_stat_t stat,
    output cfe_pkg::cfe_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_FIDV,
        ST_MID,
        ST_TAIL
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.src    = cfe_pkg::SRC_HDR;
        in_ready   = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (stat.plan_in.any)
                    begin
                        if (stat.plan_in.hdr)
                            state_next = ST_HDR;
                        else if (stat.plan_in.mid)
                            state_next = ST_MID;
                        else
                            state_next = ST_TAIL;
                    end
                end
            end
            ST_HDR:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.src  = cfe_pkg::SRC_HDR;
                    cmd.last = !(stat.plan.fidv || stat.plan.mid || stat.plan.tail);
                    if (stat.plan.fidv)
                        state_next = ST_FIDV;
                    else if (stat.plan.mid)
                        state_next = ST_MID;
                    else if (stat.plan.tail)
                        state_next = ST_TAIL;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_FIDV:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.src  = cfe_pkg::SRC_VARINT;
                    if (stat.sr_more)
                        cmd.sr_step = 1'b1;
                    else
                    begin
                        // Field id done: bring the trailing value into the shifter.
                        cmd.sr_tail = 1'b1;
                        cmd.last    = !(stat.plan.mid || stat.plan.tail);
                        if (stat.plan.mid)
                            state_next = ST_MID;
                        else if (stat.plan.tail)
                            state_next = ST_TAIL;
                        else
                            state_next = ST_IDLE;
                    end
                end
            end
            ST_MID:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.src    = cfe_pkg::SRC_MID;
                    cmd.last   = !stat.plan.tail;
                    state_next = stat.plan.tail ? ST_TAIL : ST_IDLE;
                end
            end
            ST_TAIL:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.src  = cfe_pkg::SRC_VARINT;
                    if (stat.sr_more)
                        cmd.sr_step = 1'b1;
                    else
                    begin
                        cmd.last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: sv/compact_field_encoder.sv
`timescale 1ns / 1ps
// A token's first byte passes through the item registers, then the output byte register.
// A token is taken only in idle, after the last byte of the one before is emitted; the single
// output byte register and the varint shifter (one byte per cycle unless stalled) set the pace.
// Reset clears the controller, the output valid, the nesting level and the top-level last field
// id; the id stack memory is not cleared, since every entry is written on push before it is read.
module compact_field_encoder #(
    parameter int NEST_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    cfe_in_if.sink      token,
    cfe_out_if.source   stream
);

    cfe_pkg::cfe_cmd_t  cmd;
    cfe_pkg::cfe_stat_t stat;

    cfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (token.valid),
        .in_ready (token.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cfe_datapath #(
        .NEST_DEPTH (NEST_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .kind         (token.kind),
        .fld_id       (token.fld_id),
        .int_size     (token.int_size),
        .value        (token.value),
        .count        (token.count),
        .element_type (token.element_type),
        .cmd          (cmd),
        .stat         (stat),
        .out_ready    (stream.ready),
        .out_valid    (stream.valid),
        .out_byte     (stream.out_byte),
        .out_last     (stream.last),
        .out_error    (stream.error)
    );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

    localparam int NEST_DEPTH      = 8;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int HOLD_CYCLES     = 300;
    localparam int DELTA_MAX       = 15;
    localparam int LIST_INLINE_MAX = 15;
    localparam int MAX_REPORTS     = 10;

    // Codes outside the defined sets, used to probe the fallback handling.
    localparam logic [3:0] KIND_UNUSED = 4'd15;
    localparam logic [1:0] ISZ_UNUSED  = 2'd3;

    typedef struct {
        logic [3:0]  kind;
        logic [15:0] fld_id;
        logic [1:0]  int_size;
        logic [63:0] value;
        logic [31:0] count;
        logic [3:0]  element_type;
    } token_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       error;
    } enc_byte_t;

    logic clk;
    logic rst_n;

    cfe_in_if  tok_if ();
    cfe_out_if str_if ();

    compact_field_encoder #(
        .NEST_DEPTH(NEST_DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .token  (tok_if),
        .stream (str_if)
    );

    // Tracked encoder state.
    shortint    last_ids [NEST_DEPTH];
    int         depth_lvl;
    logic [7:0] token_bytes [$];
    enc_byte_t  expected_bytes [$];

    int   mismatches;
    int   cycle_cnt;
    bit   no_idle;
    bit   hold_request;
    int   stall_left;
    int   rx_gap;
    enc_byte_t want_b;
    enc_byte_t got_b;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic logic [63:0] zigzag64(logic [63:0] u);
        return (u << 1) ^ {64{u[63]}};
    endfunction

    function automatic void put_varint(logic [63:0] v);
        while (v > 64'h7f)
        begin
            token_bytes.insert(token_bytes.size(), {1'b1, v[6:0]});
            v = v >> 7;
        end
        token_bytes.insert(token_bytes.size(), v[7:0]);
    endfunction

    function automatic void put_header(logic [15:0] fid_bits, logic [3:0] code);
        int         cur;
        int         fid;
        logic [3:0] delta;
        cur = last_ids[depth_lvl];
        fid = int'($signed(fid_bits));
        if (fid > cur && fid <= cur + DELTA_MAX)
        begin
            delta = 4'(fid - cur);
            token_bytes.insert(token_bytes.size(), {delta, code});
        end
        else
        begin
            token_bytes.insert(token_bytes.size(), {4'h0, code});
            put_varint(zigzag64({{48{fid_bits[15]}}, fid_bits}));
        end
        last_ids[depth_lvl] = shortint'(fid);
    endfunction

    // Works out the bytes one accepted token produces and queues them.
    function automatic void encode_token(token_t t);
        logic [3:0] code;
        logic       overflow;
        enc_byte_t  eb;
        overflow = 1'b0;
        token_bytes.delete();
        case (t.kind)
            cfe_pkg::KIND_INT:
            begin
                if (t.int_size == cfe_pkg::ISZ_I16)
                    code = cfe_pkg::TYPE_I16;
                else if (t.int_size == cfe_pkg::ISZ_I32)
                    code = cfe_pkg::TYPE_I32;
                else
                    code = cfe_pkg::TYPE_I64;
                put_header(t.fld_id, code);
                put_varint(zigzag64(t.value));
            end
            cfe_pkg::KIND_BOOL:
                put_header(t.fld_id, t.value[0] ? cfe_pkg::TYPE_TRUE : cfe_pkg::TYPE_FALSE);
            cfe_pkg::KIND_BYTE:
            begin
                put_header(t.fld_id, cfe_pkg::TYPE_I8);
                token_bytes.insert(token_bytes.size(), t.value[7:0]);
            end
            cfe_pkg::KIND_LIST:
            begin
                put_header(t.fld_id, cfe_pkg::TYPE_LIST);
                if (t.count >= LIST_INLINE_MAX)
                begin
                    token_bytes.insert(token_bytes.size(), {4'hf, t.element_type});
                    put_varint({32'h0, t.count});
                end
                else
                begin
                    token_bytes.insert(token_bytes.size(), {t.count[3:0], t.element_type});
                end
            end
            cfe_pkg::KIND_BIN:
            begin
                put_header(t.fld_id, cfe_pkg::TYPE_BINARY);
                put_varint({32'h0, t.count});
            end
            cfe_pkg::KIND_SELEM: put_varint(zigzag64(t.value));
            cfe_pkg::KIND_UVAR:  put_varint({32'h0, t.count});
            cfe_pkg::KIND_RAW:   token_bytes.insert(token_bytes.size(), t.value[7:0]);
            cfe_pkg::KIND_START:
            begin
                put_header(t.fld_id, cfe_pkg::TYPE_STRUCT);
                if (depth_lvl + 1 < NEST_DEPTH)
                begin
                    depth_lvl++;
                    last_ids[depth_lvl] = 0;
                end
                else
                begin
                    overflow = 1'b1;
                end
            end
            cfe_pkg::KIND_STOP:
            begin
                token_bytes.insert(token_bytes.size(), cfe_pkg::STOP_BYTE);
                if (depth_lvl > 0)
                    depth_lvl--;
                else
                    last_ids[0] = 0;
            end
            default: ;
        endcase
        foreach (token_bytes[i])
        begin
            eb.data  = token_bytes[i];
            eb.last  = (i == token_bytes.size() - 1);
            eb.error = overflow;
            expected_bytes.insert(expected_bytes.size(), eb);
        end
    endfunction

    function automatic token_t make_token(logic [3:0] kind, logic [15:0] fid,
                                          logic [1:0] isz, logic [63:0] value,
                                          logic [31:0] count, logic [3:0] etype);
        token_t t;
        t.kind         = kind;
        t.fld_id       = fid;
        t.int_size     = isz;
        t.value        = value;
        t.count        = count;
        t.element_type = etype;
        return t;
    endfunction

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        v = {$urandom, $urandom} >> $urandom_range(0, 63);
        if ($urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    // Random token, biased toward well-formed field sequences.
    function automatic token_t random_token();
        token_t t;
        int     r;
        int     base;
        base = last_ids[depth_lvl];
        r = $urandom_range(0, 99);
        if (r < 22)      t.kind = cfe_pkg::KIND_INT;
        else if (r < 32) t.kind = cfe_pkg::KIND_BOOL;
        else if (r < 40) t.kind = cfe_pkg::KIND_BYTE;
        else if (r < 50) t.kind = cfe_pkg::KIND_LIST;
        else if (r < 58) t.kind = cfe_pkg::KIND_BIN;
        else if (r < 66) t.kind = cfe_pkg::KIND_SELEM;
        else if (r < 72) t.kind = cfe_pkg::KIND_UVAR;
        else if (r < 78) t.kind = cfe_pkg::KIND_RAW;
        else if (r < 88) t.kind = cfe_pkg::KIND_START;
        else if (r < 97) t.kind = cfe_pkg::KIND_STOP;
        else             t.kind = 4'($urandom_range(cfe_pkg::KIND_STOP + 1, 15));
        r = $urandom_range(0, 99);
        if (r < 70)
            t.fld_id = 16'(base + $urandom_range(1, DELTA_MAX));
        else if (r < 80)
            t.fld_id = 16'(base - $urandom_range(0, 20));
        else if (r < 90)
            t.fld_id = 16'($urandom);
        else
            t.fld_id = 16'($urandom_range(0, 40));
        t.int_size     = 2'($urandom_range(0, 3));
        t.value        = rand_value();
        t.element_type = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 1))
            t.count = $urandom_range(0, 20);
        else
            t.count = $urandom >> $urandom_range(0, 31);
        return t;
    endfunction

    task automatic send_token(token_t t);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            tok_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        tok_if.valid        <= 1'b1;
        tok_if.kind         <= t.kind;
        tok_if.fld_id       <= t.fld_id;
        tok_if.int_size     <= t.int_size;
        tok_if.value        <= t.value;
        tok_if.count        <= t.count;
        tok_if.element_type <= t.element_type;
        @(posedge clk);
        while (!tok_if.ready)
            @(posedge clk);
        encode_token(t);
    endtask

    // Unused kinds do not count toward n.
    task automatic send_random(int n);
        token_t t;
        int     sent;
        sent = 0;
        while (sent < n)
        begin
            t = random_token();
            send_token(t);
            if (t.kind <= cfe_pkg::KIND_STOP)
                sent++;
        end
    endtask

    task automatic pause_until_drained();
        @(negedge clk);
        tok_if.valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic test_field_headers();
        send_token(make_token(cfe_pkg::KIND_INT, 16'd1, cfe_pkg::ISZ_I16, 64'd0, 32'd0, 4'd0));
        send_token(make_token(cfe_pkg::KIND_INT, 16'd16, cfe_pkg::ISZ_I32,
                              64'h7fff_ffff_ffff_ffff, 32'd0, 4'd0));
        // A delta of sixteen falls back to the long header.
        send_token(make_token(cfe_pkg::KIND_INT, 16'd32, cfe_pkg::ISZ_I64,
                              64'h8000_0000_0000_0000, 32'd0, 4'd0));
        // Repeated id, and int size three taken as i64.
        send_token(make_token(cfe_pkg::KIND_INT, 16'd32, ISZ_UNUSED, '1, 32'd0, 4'd0));
        send_token(make_token(cfe_pkg::KIND_BOOL, 16'h8000, cfe_pkg::ISZ_I16, 64'd1,
                              32'd0, 4'd0));
        send_token(make_token(cfe_pkg::KIND_BOOL, 16'h7fff, cfe_pkg::ISZ_I16, 64'd0,
                              32'd0, 4'd0));
        send_token(make_token(cfe_pkg::KIND_BYTE, 16'h7ffe, cfe_pkg::ISZ_I16,
                              64'hffff_ffff_ffff_ff80, 32'd0, 4'd0));
        // A stop at the top level clears the last field id.
        send_token(make_token(cfe_pkg::KIND_STOP, 16'd0, cfe_pkg::ISZ_I16, 64'd0, 32'd0, 4'd0));
    endtask

    task automatic test_lists_and_scalars();
        send_token(make_token(cfe_pkg::KIND_LIST, 16'd1, cfe_pkg::ISZ_I16, 64'd0, 32'd0, 4'hf));
        send_token(make_token(cfe_pkg::KIND_LIST, 16'd2, cfe_pkg::ISZ_I16, 64'd0, 32'd14, 4'h0));
        send_token(make_token(cfe_pkg::KIND_LIST, 16'd3, cfe_pkg::ISZ_I16, 64'd0, 32'd15, 4'h7));
        send_token(make_token(cfe_pkg::KIND_LIST, 16'd4, cfe_pkg::ISZ_I16, 64'd0,
                              32'hffff_ffff, 4'h9));
        send_token(make_token(cfe_pkg::KIND_BIN, 16'd5, cfe_pkg::ISZ_I16, 64'd0, 32'd0, 4'd0));
        send_token(make_token(cfe_pkg::KIND_BIN, 16'd20, cfe_pkg::ISZ_I16, 64'd0,
                              32'hffff_ffff, 4'd0));
        send_token(make_token(cfe_pkg::KIND_SELEM, 16'd0, cfe_pkg::ISZ_I16,
                              64'h7fff_ffff_ffff_ffff, 32'd0, 4'd0));
        send_token(make_token(cfe_pkg::KIND_SELEM, 16'd0, cfe_pkg::ISZ_I16,
                              64'h8000_0000_0000_0000, 32'd0, 4'd0));
        send_token(make_token(cfe_pkg::KIND_UVAR, 16'd0, cfe_pkg::ISZ_I16, 64'd0,
                              32'hffff_ffff, 4'd0));
        send_token(make_token(cfe_pkg::KIND_RAW, 16'd0, cfe_pkg::ISZ_I16, 64'hff, 32'd0, 4'd0));
        // An unused kind must leave no bytes and no trace in the state.
        send_token(make_token(KIND_UNUSED, 16'h1234, ISZ_UNUSED, '1, '1, 4'hf));
    endtask

    task automatic test_nesting_overflow();
        // Seven pushes fill the stack; the eighth start overflows.
        for (int i = 0; i < NEST_DEPTH; i++)
            send_token(make_token(cfe_pkg::KIND_START, 16'd1, cfe_pkg::ISZ_I16, 64'd0,
                                  32'd0, 4'd0));
        send_token(make_token(cfe_pkg::KIND_STOP, 16'd0, cfe_pkg::ISZ_I16, 64'd0, 32'd0, 4'd0));
    endtask

    task automatic test_random_stream();
        send_random(175);
    endtask

    task automatic test_backpressure();
        hold_request = 1'b1;
        no_idle      = 1'b1;
        send_random(40);
        no_idle      = 1'b0;
        pause_until_drained();
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        send_random(90);
        no_idle = 1'b0;
    endtask

    task automatic note_mismatch(string what, enc_byte_t want, enc_byte_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t %s: expected byte %02h last %0b error %0b, got byte %02h last %0b error %0b",
                     $realtime, what, want.data, want.last, want.error,
                     got.data, got.last, got.error);
    endtask

    // Output receiver: random stalls, plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            str_if.ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (hold_request)
        begin
            str_if.ready <= 1'b0;
            stall_left   = HOLD_CYCLES - 1;
            hold_request = 1'b0;
        end
        else
        begin
            rx_gap = pick_gap();
            str_if.ready <= (rx_gap == 0);
            stall_left = (rx_gap > 0) ? rx_gap - 1 : 0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && str_if.valid && str_if.ready)
        begin
            got_b = '{data: str_if.out_byte, last: str_if.last, error: str_if.error};
            if (expected_bytes.size() == 0)
            begin
                note_mismatch("unexpected transaction", '0, got_b);
            end
            else
            begin
                want_b = expected_bytes.pop_front();
                if (want_b.data !== got_b.data || want_b.last !== got_b.last ||
                    want_b.error !== got_b.error)
                    note_mismatch("mismatch", want_b, got_b);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        tok_if.valid        = 1'b0;
        tok_if.kind         = '0;
        tok_if.fld_id       = '0;
        tok_if.int_size     = '0;
        tok_if.value        = '0;
        tok_if.count        = '0;
        tok_if.element_type = '0;
        str_if.ready        = 1'b0;
        mismatches          = 0;
        cycle_cnt           = 0;
        no_idle             = 1'b0;
        hold_request        = 1'b0;
        stall_left          = 0;
        depth_lvl           = 0;
        foreach (last_ids[i])
            last_ids[i] = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_field_headers();
        test_lists_and_scalars();
        test_nesting_overflow();
        test_random_stream();
        test_backpressure();
        test_back_to_back();

        pause_until_drained();
        if (expected_bytes.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
